[rtl/core/gdi_pkg.sv]
// Shared constants and calendar tables for the Gregorian date information block.
`timescale 1ns / 1ps

package gdi_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int ShYearW = YearW + 1;   // year shifted by 400, still positive
  localparam int DoyW   = 9;
  localparam int WdW    = 3;
  localparam int MaskW  = 7;
  localparam int CentW  = 8;            // year / 100 for years below 25600

  // floor(x / 100) == (x * Div100Mul) >> Div100Shift for x below 2**15
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int          Div100Shift = 19;

  localparam logic [ShYearW-1:0] YearBias = ShYearW'(400);
  localparam logic [6:0]         Hundred  = 7'd100;
  localparam logic [WdW-1:0]     Saturday = 3'd6;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  localparam logic [DoyW-1:0] CommonYearLen = 9'd365;
  localparam logic [DoyW-1:0] LeapYearLen   = 9'd366;

  // month length, zero for a month code outside January to December
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // floor(31 * mm / 12) with March as month one of the shifted year
  function automatic logic [5:0] month_shift(input logic [MonthW-1:0] m);
    logic [5:0] r;
    case (m)
      4'd1:    r = 6'd28;
      4'd2:    r = 6'd31;
      4'd3:    r = 6'd2;
      4'd4:    r = 6'd5;
      4'd5:    r = 6'd7;
      4'd6:    r = 6'd10;
      4'd7:    r = 6'd12;
      4'd8:    r = 6'd15;
      4'd9:    r = 6'd18;
      4'd10:   r = 6'd20;
      4'd11:   r = 6'd23;
      4'd12:   r = 6'd25;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // residue modulo 7 by folding octal digits, since 8 is 1 modulo 7
  function automatic logic [WdW-1:0] mod7(input logic [ShYearW-1:0] s);
    logic [5:0] t1;
    logic [3:0] t2;
    logic [3:0] t3;
    t1 = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
    t2 = 4'(t1[2:0]) + 4'(t1[5:3]);
    t3 = 4'(t2[2:0]) + 4'(t2[3]);
    return (t3 == 4'd7) ? 3'd0 : t3[2:0];
  endfunction

endpackage

[rtl/core/gregorian_date_info.sv]
// Top level of the Gregorian date information block: four-stage date pipeline.
`timescale 1ns / 1ps

// Takes one Gregorian date word (day, month, year) and returns one result word with the
// weekday (0 Sunday), leap flag, day of year, days left to Saturday, month end and year
// end (the last two counting today), and end-of-week, weekend and business-day flags.
// A month outside 1..12 or a day outside 1..month length sets bad_date and zeroes every
// count and flag except leap_year. The weekend days come from cfg_wdata, written when
// cfg_we is high (reset: Friday and Saturday); write it only while the block is idle.
// One date is accepted every cycle while results are taken. A taken date passes the input
// register, the constant-reciprocal divide by 100 and the calendar sums, then modulo 7
// into the result register, where out_valid rises with it. A held result stalls the
// input once all four registers hold words.
module gregorian_date_info (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [gdi_pkg::MaskW-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gdi_pkg::DayW-1:0]     day_of_month,
  input  logic [gdi_pkg::MonthW-1:0]   month_number,
  input  logic [gdi_pkg::YearW-1:0]    year_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gdi_pkg::WdW-1:0]      weekday,
  output logic                         leap_year,
  output logic [gdi_pkg::DoyW-1:0]     day_of_year,
  output logic [gdi_pkg::WdW-1:0]      days_to_week_end,
  output logic [gdi_pkg::DayW-1:0]     days_to_month_end,
  output logic [gdi_pkg::DoyW-1:0]     days_to_year_end,
  output logic                         end_of_week,
  output logic                         weekend_day,
  output logic                         business_day,
  output logic                         bad_date
);
  import gdi_pkg::*;

  logic [MaskW-1:0] weekend_mask;

  // stage valids and advance conditions
  logic v0, v1, v2;
  logic adv0, adv1, adv2, adv3;

  // stage 0: captured date
  logic [DayW-1:0]   d0;
  logic [MonthW-1:0] m0;
  logic [YearW-1:0]  y0;

  // stage 1: shifted year and centuries
  logic [DayW-1:0]    d1;
  logic [MonthW-1:0]  m1;
  logic [YearW-1:0]   y1;
  logic [ShYearW-1:0] yy1;
  logic [CentW-1:0]   cyy1;
  logic [CentW-1:0]   cy1;

  // stage 2: calendar sums
  logic               leap2;
  logic               bad2;
  logic [ShYearW-1:0] s2;
  logic [DoyW-1:0]    doy2;
  logic [DayW-1:0]    mlen2;
  logic [DayW-1:0]    d2;

  // stage 1 logic
  logic               feb_or_jan;
  logic [ShYearW-1:0] yy_next;
  logic [27:0]        pyy;
  logic [26:0]        py;

  // stage 2 logic
  logic               leap_next;
  logic [DayW-1:0]    mlen_next;
  logic               bad_next;
  logic [ShYearW-1:0] s_next;
  logic [DoyW-1:0]    doy_next;
  logic [YearW-1:0]   cent_back;

  // stage 3 logic
  logic [WdW-1:0]     wd;

  assign adv3     = !out_valid || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign adv0     = !v0 || adv1;
  assign in_ready = adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      weekend_mask <= MaskW'(96);
    end else if (cfg_we) begin
      weekend_mask <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv0) begin
        v0 <= in_valid;
      end
      if (adv1) begin
        v1 <= v0;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        out_valid <= v2;
      end
    end
  end

  // stage 0: take the word
  always_ff @(posedge clk) begin
    if (adv0) begin
      d0 <= day_of_month;
      m0 <= month_number;
      y0 <= year_number;
    end
  end

  // stage 1: January and February belong to the previous shifted year
  assign feb_or_jan = (m0 == MonJan) || (m0 == MonFeb);
  assign yy_next    = ShYearW'(y0) + YearBias - ShYearW'(feb_or_jan);
  assign pyy        = 28'(yy_next) * 28'(Div100Mul);
  assign py         = 27'(y0) * 27'(Div100Mul);

  always_ff @(posedge clk) begin
    if (adv1) begin
      d1   <= d0;
      m1   <= m0;
      y1   <= y0;
      yy1  <= yy_next;
      cyy1 <= pyy[Div100Shift +: CentW];
      cy1  <= py[Div100Shift +: CentW];
    end
  end

  // stage 2: leap year, validity, day of year and weekday sum
  assign cent_back = YearW'(cy1) * YearW'(Hundred);
  assign leap_next = (y1[1:0] == 2'b00) && ((cent_back != y1) || (cy1[1:0] == 2'b00));
  assign mlen_next = month_len(m1, leap_next);
  assign bad_next  = (mlen_next == '0) || (d1 == '0) || (d1 > mlen_next);
  assign doy_next  = days_before(m1) + DoyW'(d1)
                   + DoyW'(leap_next && (m1 > MonFeb) && (m1 <= MonDec));
  assign s_next    = ShYearW'(d1) + yy1 + (yy1 >> 2) - ShYearW'(cyy1)
                   + ShYearW'(cyy1 >> 2) + ShYearW'(month_shift(m1));

  always_ff @(posedge clk) begin
    if (adv2) begin
      leap2 <= leap_next;
      bad2  <= bad_next;
      s2    <= s_next;
      doy2  <= doy_next;
      mlen2 <= mlen_next;
      d2    <= d1;
    end
  end

  // stage 3: reduce to a weekday, zero everything but the leap flag on a bad date
  assign wd = mod7(s2);

  always_ff @(posedge clk) begin
    if (adv3) begin
      leap_year <= leap2;
      bad_date  <= bad2;
      if (bad2) begin
        weekday           <= '0;
        day_of_year       <= '0;
        days_to_week_end  <= '0;
        days_to_month_end <= '0;
        days_to_year_end  <= '0;
        end_of_week       <= 1'b0;
        weekend_day       <= 1'b0;
        business_day      <= 1'b0;
      end else begin
        weekday           <= wd;
        day_of_year       <= doy2;
        days_to_week_end  <= Saturday - wd;
        days_to_month_end <= mlen2 - d2 + DayW'(1);
        days_to_year_end  <= (leap2 ? LeapYearLen : CommonYearLen) + DoyW'(1) - doy2;
        end_of_week       <= (wd == Saturday);
        weekend_day       <= weekend_mask[wd];
        business_day      <= !weekend_mask[wd];
      end
    end
  end

endmodule

[dv/tb.sv]
// Self-checking testbench for the Gregorian date information block.
`timescale 1ns / 1ps

module tb;
  import gdi_pkg::*;

  localparam logic [MaskW-1:0] MaskAtReset = 7'd96;
  localparam int unsigned      CycleLimit  = 200000;
  localparam int unsigned      HoldCycles  = 300;
  localparam int unsigned      PhaseWords  = 250;
  localparam int unsigned      PrintLimit  = 100;

  typedef struct {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct {
    date_t             date;
    logic [WdW-1:0]    weekday;
    logic              leap;
    logic [DoyW-1:0]   doy;
    logic [WdW-1:0]    to_week_end;
    logic [DayW-1:0]   to_month_end;
    logic [DoyW-1:0]   to_year_end;
    logic              eow;
    logic              weekend;
    logic              business;
    logic              bad;
  } info_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [MaskW-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DayW-1:0]     day_of_month = '0;
  logic [MonthW-1:0]   month_number = '0;
  logic [YearW-1:0]    year_number = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [WdW-1:0]      weekday;
  logic                leap_year;
  logic [DoyW-1:0]     day_of_year;
  logic [WdW-1:0]      days_to_week_end;
  logic [DayW-1:0]     days_to_month_end;
  logic [DoyW-1:0]     days_to_year_end;
  logic                end_of_week;
  logic                weekend_day;
  logic                business_day;
  logic                bad_date;

  date_t               dates_to_send[$];
  info_t               info_due[$];
  logic [MaskW-1:0]    weekend_bits = MaskAtReset;
  bit                  idling = 1'b1;
  bit                  hold_req = 1'b0;
  bit                  word_taken = 1'b0;
  bit                  res_taken = 1'b0;
  int unsigned         tx_wait = 0;
  int unsigned         rx_wait = 0;
  int unsigned         long_hold = 0;
  int unsigned         fail_count = 0;
  int unsigned         cycle_count = 0;

  gregorian_date_info i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .day_of_month      (day_of_month),
    .month_number      (month_number),
    .year_number       (year_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .weekday           (weekday),
    .leap_year         (leap_year),
    .day_of_year       (day_of_year),
    .days_to_week_end  (days_to_week_end),
    .days_to_month_end (days_to_month_end),
    .days_to_year_end  (days_to_year_end),
    .end_of_week       (end_of_week),
    .weekend_day       (weekend_day),
    .business_day      (business_day),
    .bad_date          (bad_date)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit leap_of(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_days(int unsigned m, bit leap);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic info_t date_info_of(date_t dt, logic [MaskW-1:0] mask);
    info_t       r;
    int unsigned d, m, y, mlen, doy, a, yy, mm, wd, i;
    bit          leap;
    d = dt.day;
    m = dt.month;
    y = dt.year;
    leap = leap_of(y);
    mlen = month_days(m, leap);
    r.date = dt;
    r.leap = leap;
    r.bad = (mlen == 0) || (d < 1) || (d > mlen);
    r.weekday = '0;
    r.doy = '0;
    r.to_week_end = '0;
    r.to_month_end = '0;
    r.to_year_end = '0;
    r.eow = 1'b0;
    r.weekend = 1'b0;
    r.business = 1'b0;
    if (!r.bad) begin
      // shift the year so that March opens it; 400 extra years keep the weekday
      a = (14 - m) / 12;
      yy = y + 400 - a;
      mm = m + 12 * a - 2;
      wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      doy = d;
      for (i = 1; i < m; i++) doy += month_days(i, leap);
      r.weekday = WdW'(wd);
      r.doy = DoyW'(doy);
      r.to_week_end = WdW'(6 - wd);
      r.to_month_end = DayW'(mlen - d + 1);
      r.to_year_end = DoyW'((leap ? LeapYearLen : CommonYearLen) + 1 - doy);
      r.eow = (r.weekday == Saturday);
      r.weekend = mask[wd];
      r.business = !mask[wd];
    end
    return r;
  endfunction

  function automatic int unsigned pause_len();
    return idling ? $urandom_range(0, 8) : 0;
  endfunction

  task automatic report(string msg);
    if (fail_count < PrintLimit) $display("ERROR %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic cmp(string field, logic [8:0] got, logic [8:0] want, date_t dt);
    if (got !== want)
      report($sformatf("%0d-%0d-%0d %s: got %0d expected %0d",
                       dt.year, dt.month, dt.day, field, got, want));
  endtask

  // sender: hold each word until taken, then wait a drawn number of cycles
  always @(negedge clk) begin : drv
    date_t dt;
    bit    busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && !word_taken;
      if (word_taken) begin
        word_taken = 1'b0;
        tx_wait = pause_len();
      end
      if (!busy) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (dates_to_send.size() != 0) begin
          dt = dates_to_send.pop_front();
          day_of_month <= dt.day;
          month_number <= dt.month;
          year_number <= dt.year;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall a drawn number of cycles after each result, or a long hold on request
  always @(negedge clk) begin : rcv
    logic nxt;
    if (res_taken) begin
      res_taken = 1'b0;
      rx_wait = pause_len();
    end
    if (rst) begin
      nxt = 1'b0;
    end else if (long_hold != 0) begin
      long_hold--;
      nxt = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      long_hold = HoldCycles - 1;
      nxt = 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait--;
      nxt = 1'b0;
    end else begin
      nxt = 1'b1;
    end
    out_ready <= nxt;
  end

  always @(posedge clk) begin : mon
    date_t dt;
    info_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        dt.day = day_of_month;
        dt.month = month_number;
        dt.year = year_number;
        info_due.push_back(date_info_of(dt, weekend_bits));
        word_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        res_taken = 1'b1;
        if (info_due.size() == 0) begin
          report("result word with none expected");
        end else begin
          want = info_due.pop_front();
          cmp("weekday", 9'(weekday), 9'(want.weekday), want.date);
          cmp("leap_year", 9'(leap_year), 9'(want.leap), want.date);
          cmp("day_of_year", 9'(day_of_year), 9'(want.doy), want.date);
          cmp("days_to_week_end", 9'(days_to_week_end), 9'(want.to_week_end), want.date);
          cmp("days_to_month_end", 9'(days_to_month_end), 9'(want.to_month_end),
              want.date);
          cmp("days_to_year_end", 9'(days_to_year_end), 9'(want.to_year_end), want.date);
          cmp("end_of_week", 9'(end_of_week), 9'(want.eow), want.date);
          cmp("weekend_day", 9'(weekend_day), 9'(want.weekend), want.date);
          cmp("business_day", 9'(business_day), 9'(want.business), want.date);
          cmp("bad_date", 9'(bad_date), 9'(want.bad), want.date);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count = cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout with %0d results outstanding", info_due.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic drain();
    while (dates_to_send.size() != 0 || in_valid || info_due.size() != 0) begin
      @(posedge clk);
      #1;
    end
    // let the pipeline settle
    repeat (6) @(posedge clk);
    #1;
  endtask

  task automatic write_mask(logic [MaskW-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    weekend_bits = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stim
    logic [MaskW-1:0] masks[7];
    date_t            dt;
    int unsigned      ph, n, kind, mlen;
    masks = '{7'h00, 7'h7F, 7'h41, 7'h01, 7'h40, 7'h00, 7'h00};
    masks[5] = MaskW'($urandom_range(0, 127));
    masks[6] = MaskW'($urandom_range(0, 127));

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed dates under the reset weekend mask
    dates_to_send.push_back('{5'd1,  4'd1,  14'd1});
    dates_to_send.push_back('{5'd31, 4'd12, 14'd9999});
    dates_to_send.push_back('{5'd29, 4'd2,  14'd2000});
    dates_to_send.push_back('{5'd29, 4'd2,  14'd1900});
    dates_to_send.push_back('{5'd29, 4'd2,  14'd2024});
    dates_to_send.push_back('{5'd29, 4'd2,  14'd2023});
    dates_to_send.push_back('{5'd28, 4'd2,  14'd2023});
    dates_to_send.push_back('{5'd1,  4'd3,  14'd2024});
    dates_to_send.push_back('{5'd31, 4'd12, 14'd2024});
    dates_to_send.push_back('{5'd0,  4'd5,  14'd2024});
    dates_to_send.push_back('{5'd31, 4'd4,  14'd2024});
    dates_to_send.push_back('{5'd10, 4'd0,  14'd2024});
    dates_to_send.push_back('{5'd10, 4'd13, 14'd2024});
    dates_to_send.push_back('{5'd31, 4'd15, 14'd16383});
    dates_to_send.push_back('{5'd1,  4'd1,  14'd0});
    dates_to_send.push_back('{5'd29, 4'd2,  14'd0});
    dates_to_send.push_back('{5'd31, 4'd12, 14'd16383});
    dates_to_send.push_back('{5'd1,  4'd3,  14'd10000});
    dates_to_send.push_back('{5'd31, 4'd1,  14'd8191});
    dates_to_send.push_back('{5'd1,  4'd6,  14'd2024});
    dates_to_send.push_back('{5'd2,  4'd6,  14'd2024});
    dates_to_send.push_back('{5'd7,  4'd6,  14'd2024});

    for (ph = 0; ph < 7; ph++) begin
      drain();
      write_mask(masks[ph]);
      idling = (ph % 3) != 1;
      for (n = 0; n < PhaseWords; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 60)      dt.year = YearW'($urandom_range(1, 9999));
        else if (kind < 80) dt.year = YearW'($urandom_range(0, 163) * 100 + $urandom_range(0, 8));
        else                dt.year = YearW'($urandom_range(0, 16383));
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          dt.month = MonthW'($urandom_range(1, 12));
          mlen = month_days(dt.month, leap_of(dt.year));
          // favour the first and last day of the month
          if (kind < 8)       dt.day = DayW'(mlen);
          else if (kind < 14) dt.day = DayW'(1);
          else                dt.day = DayW'($urandom_range(1, mlen));
        end else if (kind < 90) begin
          dt.month = MonthW'($urandom_range(1, 12));
          dt.day = DayW'(month_days(dt.month, leap_of(dt.year)) + 1);
        end else begin
          dt.month = MonthW'($urandom_range(0, 15));
          dt.day = DayW'($urandom_range(0, 31));
        end
        dates_to_send.push_back(dt);
      end
      // hold off the receiver so that the pipeline backs up into the input
      if (ph == 2) hold_req = 1'b1;
    end

    drain();
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
